### src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and codes for the timer with compare and countdown.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int ActionW = 2;
    localparam int AddrW   = 8;
    localparam int DataW   = 32;
    localparam int CountW  = 64;
    localparam int EventW  = 2;
    localparam int WordW   = AddrW - 2;

    localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
    localparam logic [ActionW-1:0] ACT_READ  = 2'd1;
    localparam logic [ActionW-1:0] ACT_WRITE = 2'd2;

    localparam logic [WordW-1:0] WORD_WALLCLOCK = 6'd0;
    localparam logic [WordW-1:0] WORD_COUNT_LO  = 6'd1;
    localparam logic [WordW-1:0] WORD_COUNT_HI  = 6'd2;
    localparam logic [WordW-1:0] WORD_CMP_LO    = 6'd3;
    localparam logic [WordW-1:0] WORD_CMP_HI    = 6'd4;
    localparam logic [WordW-1:0] WORD_COUNTDOWN = 6'd5;

    typedef struct packed {
        logic [DataW-1:0]  read_data;
        logic              access_ok;
        logic [EventW-1:0] event_count;
    } t_result;

endpackage

`default_nettype wire

### src/timer_compare_countdown_device.sv
// A result is registered in the output entry, or in the skid entry while the output is held.
// One item per cycle while the skid entry is empty; the 64-bit increment and compare bound the cycle.
// A two-entry output stage keeps accepting while one result waits to be taken.
// Reset (synchronous, active low) clears counter, compare and countdown to zero
// and empties the output stage.
// ----------------------------------------------------------------------------
// timer_compare_countdown_device
// Bus-mapped timer with 64-bit cycle counter, compare event and countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_compare_countdown_device
    import tcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [39:0]        i_s_tdata,  // address[7:0], write_data[39:8]
    input  wire logic [ActionW-1:0] i_s_tuser,  // action[1:0]
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [39:0]             o_m_tdata,  // read_data[31:0], event_count[33:32], zero pad
    output logic                    o_m_tuser   // access_ok
);

    t_result r_out, r_skid, core_res;
    logic    r_out_vld, r_skid_vld;
    logic    push, pop;

    assign o_s_tready = !r_skid_vld;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = r_out_vld && i_m_tready;

    tcc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push),
        .i_action     (i_s_tuser),
        .i_address    (i_s_tdata[AddrW-1:0]),
        .i_write_data (i_s_tdata[AddrW+DataW-1:AddrW]),
        .o_result     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || pop) begin
            r_out_vld  <= r_skid_vld || push;
            r_skid_vld <= 1'b0;
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || pop) begin
            r_out <= r_skid_vld ? r_skid : core_res;
        end else if (push) begin
            r_skid <= core_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_out.event_count, r_out.read_data};
    assign o_m_tuser  = r_out.access_ok;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without an output entry");

    a_stall_keeps_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result lost or changed");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_m_tready) |=> (r_out_vld && r_out == $past(r_skid)))
        else $error("skid entry not moved to output");
`endif

endmodule

`default_nettype wire

### src/tcc_core.sv
// ----------------------------------------------------------------------------
// tcc_core
// Timer state and single-pass evaluation of one tick, read or write.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_core
    import tcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [ActionW-1:0] i_action,
    input  wire logic [AddrW-1:0]   i_address,
    input  wire logic [DataW-1:0]   i_write_data,
    output t_result                 o_result
);

    logic [CountW-1:0] r_cycle_cnt, n_cycle_cnt;
    logic [CountW-1:0] r_compare,   n_compare;
    logic [DataW-1:0]  r_countdown, n_countdown;

    logic [WordW-1:0]  word;
    logic [CountW-1:0] cnt_inc;
    logic              cmp_hit;
    logic              cd_hit;

    assign word    = i_address[AddrW-1:2];
    assign cnt_inc = r_cycle_cnt + {{(CountW-1){1'b0}}, 1'b1};
    assign cmp_hit = (r_compare != '0) && (cnt_inc == r_compare);
    assign cd_hit  = (r_countdown == {{(DataW-1){1'b0}}, 1'b1});

    always_comb begin
        n_cycle_cnt = r_cycle_cnt;
        n_compare   = r_compare;
        n_countdown = r_countdown;
        o_result    = '0;
        unique case (i_action)
            ACT_TICK: begin
                n_cycle_cnt          = cnt_inc;
                if (r_countdown != '0) begin
                    n_countdown = r_countdown - {{(DataW-1){1'b0}}, 1'b1};
                end
                o_result.access_ok   = 1'b1;
                o_result.event_count = {1'b0, cmp_hit} + {1'b0, cd_hit};
            end
            ACT_READ: begin
                o_result.access_ok = 1'b1;
                unique case (word)
                    WORD_WALLCLOCK: o_result.read_data = '0;
                    WORD_COUNT_LO:  o_result.read_data = r_cycle_cnt[DataW-1:0];
                    WORD_COUNT_HI:  o_result.read_data = r_cycle_cnt[CountW-1:DataW];
                    WORD_CMP_LO:    o_result.read_data = r_compare[DataW-1:0];
                    WORD_CMP_HI:    o_result.read_data = r_compare[CountW-1:DataW];
                    WORD_COUNTDOWN: o_result.read_data = r_countdown;
                    default:        o_result.access_ok = 1'b0;
                endcase
            end
            ACT_WRITE: begin
                o_result.access_ok = 1'b1;
                unique case (word)
                    WORD_CMP_LO:    n_compare[DataW-1:0]      = i_write_data;
                    WORD_CMP_HI:    n_compare[CountW-1:DataW] = i_write_data;
                    WORD_COUNTDOWN: n_countdown               = i_write_data;
                    default:        o_result.access_ok        = 1'b0;
                endcase
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_cnt <= '0;
            r_compare   <= '0;
            r_countdown <= '0;
        end else if (i_accept) begin
            r_cycle_cnt <= n_cycle_cnt;
            r_compare   <= n_compare;
            r_countdown <= n_countdown;
        end
    end

`ifndef SYNTHESIS
    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_action == ACT_TICK) |=>
            (r_cycle_cnt == $past(cnt_inc)))
        else $error("cycle counter did not advance on tick");

    a_events_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_action != ACT_TICK) |-> (o_result.event_count == '0))
        else $error("event raised outside a tick");

    a_counter_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_accept || i_action != ACT_TICK) |=> $stable(r_cycle_cnt))
        else $error("cycle counter moved without a tick");
`endif

endmodule

`default_nettype wire
